>>> sv/quadrature_speed_odometer_assert.svh
// Assertion macros for the odometer RTL (included by qso_back).
`ifndef QUADRATURE_SPEED_ODOMETER_ASSERT_SVH
`define QUADRATURE_SPEED_ODOMETER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define QSO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define QSO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/qso_pkg.sv
// Shared types and constants for the quadrature speed odometer.
`timescale 1ns / 1ps
`default_nettype none
package qso_pkg;

	// Input request kinds
	localparam logic [1:0] FUNC_EDGE_A = 2'd0;
	localparam logic [1:0] FUNC_EDGE_B = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SAMPLE_PERIOD  = 2'd0;
	localparam logic [1:0] CFG_STOP_TIMEOUT   = 2'd1;
	localparam logic [1:0] CFG_SPEED_SCALE    = 2'd2;
	localparam logic [1:0] CFG_DISTANCE_SCALE = 2'd3;

	// Configuration reset values
	localparam logic [15:0] RST_SAMPLE_PERIOD  = 16'd200;
	localparam logic [15:0] RST_STOP_TIMEOUT   = 16'd2000;
	localparam logic [31:0] RST_SPEED_SCALE    = 32'd1080900;
	localparam logic [31:0] RST_DISTANCE_SCALE = 32'd60050;

	// 0.621371 in Q16
	localparam logic [15:0] MPH_Q16 = 16'd40722;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_RND,
		BK_MPH,
		BK_FIN
	} back_state_t;

endpackage
`default_nettype wire

>>> sv/qso_front.sv
// Front end: edge counting, timers and sample snapshots.
`timescale 1ns / 1ps
`default_nettype none
module qso_front
	import qso_pkg::*;
#(
	parameter int COUNT_WIDTH = 32,
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               func,
	input  wire logic                     level_a,
	input  wire logic                     level_b,
	input  wire logic [15:0]              sample_period,
	input  wire logic [15:0]              stop_timeout,
	input  wire logic                     q_full,
	output logic                          q_push,
	output logic [2*COUNT_WIDTH:0]        q_data
);

	localparam int CMPW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic [COUNT_WIDTH-1:0] count_q, last_q;
	logic [TIMER_WIDTH-1:0] st_q, sp_q;
	logic [TIMER_WIDTH-1:0] st_inc, sp_inc;
	logic                   accept, is_edge, is_tick, up, sample_hit, stop_now;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_edge  = (func == FUNC_EDGE_A) || (func == FUNC_EDGE_B);
	assign is_tick  = (func == FUNC_TICK);
	assign up       = (func == FUNC_EDGE_A) ? (level_a == level_b) : (level_a != level_b);

	// saturating timers
	assign st_inc = (st_q == '1) ? st_q : st_q + 1'b1;
	assign sp_inc = (sp_q == '1) ? sp_q : sp_q + 1'b1;

	assign sample_hit = CMPW'(st_inc) >= CMPW'(sample_period);
	assign stop_now   = CMPW'(sp_inc) > CMPW'(stop_timeout);

	assign q_push = accept && is_tick && sample_hit;
	assign q_data = {stop_now, count_q - last_q, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
			st_q    <= '0;
			sp_q    <= '0;
		end else if (accept) begin
			if (is_edge) begin
				count_q <= up ? count_q + 1'b1 : count_q - 1'b1;
				sp_q    <= '0;
			end else if (is_tick) begin
				sp_q <= sp_inc;
				if (sample_hit) begin
					st_q   <= '0;
					last_q <= count_q;
				end else begin
					st_q <= st_inc;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/qso_queue.sv
// Two-entry queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module qso_queue #(
	parameter int WIDTH = 65
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

>>> sv/qso_back.sv
// Back end: speed and distance arithmetic and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_speed_odometer_assert.svh"
module qso_back
	import qso_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire logic [2*COUNT_WIDTH:0] q_head,
	output logic                       q_pop,
	input  wire logic [31:0]           speed_scale,
	input  wire logic [31:0]           distance_scale,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                position_count,
	output logic [31:0]                delta_count,
	output logic [31:0]                speed_kmh_milli,
	output logic [31:0]                speed_mph_milli,
	output logic [47:0]                distance_mm,
	output logic                       stopped
);

	localparam int CW  = COUNT_WIDTH;
	localparam int MW  = (CW > 32) ? CW : 32;
	localparam int PW  = CW + 16;
	localparam int DW  = CW + 17;
	localparam int SW  = (DW > 47) ? DW : 47;

	back_state_t state_q, state_d;

	// snapshot split
	logic [CW-1:0] h_count, h_delta, h_cmag, h_dmag;
	logic          h_cneg, h_dneg, h_stop;
	logic [MW-1:0] h_dext, h_dlim;
	logic [31:0]   h_dmag32;

	logic          cneg_q, dneg_q, stop_q;
	logic [CW-1:0] cmag_q;
	logic [31:0]   dmag_q;
	logic [63:0]   pk_q, pm_q;
	logic [PW-1:0] pdl_q, pdh_q;
	logic [47:0]   kmh_q;
	logic [DW-1:0] dist_q;

	// final stage
	logic [47:0]   mph_w;
	logic [30:0]   kmh_mag, mph_mag;
	logic [SW-1:0] dist_ext;
	logic [46:0]   dist_mag;
	logic          load;

	assign h_count = q_head[CW-1:0];
	assign h_delta = q_head[2*CW-1:CW];
	assign h_stop  = q_head[2*CW];
	assign h_cneg  = h_count[CW-1];
	assign h_dneg  = h_delta[CW-1];
	assign h_cmag  = h_cneg ? -h_count : h_count;
	assign h_dmag  = h_dneg ? -h_delta : h_delta;
	// delta clamps to the 32-bit signed range
	assign h_dext   = MW'(h_dmag);
	assign h_dlim   = h_dneg ? MW'(32'h8000_0000) : MW'(32'h7FFF_FFFF);
	assign h_dmag32 = (h_dext > h_dlim) ? 32'(h_dlim) : 32'(h_dext);

	assign mph_w   = 48'(pm_q >> 16) + 48'(pm_q[15]);
	assign kmh_mag = stop_q ? '0 : ((kmh_q > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : kmh_q[30:0]);
	assign mph_mag = stop_q ? '0 : ((mph_w > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : mph_w[30:0]);
	assign dist_ext = SW'(dist_q);
	assign dist_mag = (dist_ext > SW'(47'h7FFF_FFFF_FFFF)) ? 47'h7FFF_FFFF_FFFF
		: 47'(dist_ext);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: state_d = BK_RND;
			BK_RND: state_d = BK_MPH;
			BK_MPH: state_d = BK_FIN;
			BK_FIN: begin
				if (!out_valid || out_ready) begin
					load    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cneg_q <= h_cneg;
			cmag_q <= h_cmag;
			dneg_q <= h_dneg;
			dmag_q <= h_dmag32;
			stop_q <= h_stop;
		end
		if (state_q == BK_MUL) begin
			pk_q  <= 64'(dmag_q) * 64'(speed_scale);
			pdl_q <= PW'(cmag_q) * PW'(distance_scale[15:0]);
			pdh_q <= PW'(cmag_q) * PW'(distance_scale[31:16]);
		end
		if (state_q == BK_RND) begin
			kmh_q  <= 48'(pk_q >> 16) + 48'(pk_q[15]);
			dist_q <= DW'(pdh_q) + DW'(pdl_q >> 16) + DW'(pdl_q[15]);
		end
		if (state_q == BK_MPH) begin
			pm_q <= 64'(kmh_q) * 64'(MPH_Q16);
		end
		if (load) begin
			position_count  <= cneg_q ? -32'(cmag_q) : 32'(cmag_q);
			delta_count     <= dneg_q ? -dmag_q : dmag_q;
			speed_kmh_milli <= dneg_q ? -{1'b0, kmh_mag} : {1'b0, kmh_mag};
			speed_mph_milli <= dneg_q ? -{1'b0, mph_mag} : {1'b0, mph_mag};
			distance_mm     <= cneg_q ? -{1'b0, dist_mag} : {1'b0, dist_mag};
			stopped         <= stop_q;
		end
	end

	`QSO_ASSERT_NXT(a_pop_starts_mul, q_pop, state_q == BK_MUL, "pop did not start multiply")
	`QSO_ASSERT_NXT(a_fin_waits, state_q == BK_FIN && out_valid && !out_ready,
		state_q == BK_FIN, "result dropped while output stalled")
	`QSO_ASSERT_IMP(a_stop_zero, out_valid && stopped,
		speed_kmh_milli == 32'd0 && speed_mph_milli == 32'd0, "speed not zero when stopped")
	`QSO_ASSERT_IMP(a_kmh_sign, out_valid && speed_kmh_milli != 32'd0,
		speed_kmh_milli[31] == delta_count[31], "speed sign differs from delta sign")

endmodule
`default_nettype wire

>>> sv/quadrature_speed_odometer.sv
// Top level of the quadrature speed odometer: ports, configuration, wiring.
// m_axis_tvalid rises after a sampling tick's snapshot has passed the queue and the back end.
// Throughput: one request per cycle while the two-entry queue has room (ready drops only
// when full); the back end takes one sample at a time: pop, three arithmetic steps, load.
// Reset (arst_n low, asynchronous): counts, timers, queue and output valid clear; the
// configuration returns to period 200, timeout 2000, speed scale 1080900, distance 60050.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_speed_odometer
	import qso_pkg::*;
#(
	parameter int COUNT_WIDTH = 32,
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// item stream in
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [0] level_a, [1] level_b, [7:2] zero
	input  wire logic [1:0]   s_axis_tuser,  // [1:0] func
	// result stream out
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [31:0] position_count, [63:32] delta_count, [95:64] speed_kmh_milli,
	// [127:96] speed_mph_milli, [175:128] distance_mm, [176] stopped, [183:177] zero
	output logic [183:0]      m_axis_tdata,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int QW = 2 * COUNT_WIDTH + 1;

	logic [15:0] period_q, timeout_q;
	logic [31:0] speed_scale_q, dist_scale_q;

	logic          q_push, q_pop, q_full, q_empty;
	logic [QW-1:0] q_wdata, q_head;

	logic [31:0] pos, dlt, kmh, mph;
	logic [47:0] mm;
	logic        stp;

	// config is always taken; the host must write only while no request is in flight (not enforced)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= RST_SAMPLE_PERIOD;
			timeout_q     <= RST_STOP_TIMEOUT;
			speed_scale_q <= RST_SPEED_SCALE;
			dist_scale_q  <= RST_DISTANCE_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_PERIOD:  period_q      <= cfg_data[15:0];
				CFG_STOP_TIMEOUT:   timeout_q     <= cfg_data[15:0];
				CFG_SPEED_SCALE:    speed_scale_q <= cfg_data;
				CFG_DISTANCE_SCALE: dist_scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: counting and sample snapshot
	qso_front #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.func         (s_axis_tuser),
		.level_a      (s_axis_tdata[0]),
		.level_b      (s_axis_tdata[1]),
		.sample_period(period_q),
		.stop_timeout (timeout_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	qso_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// back: scaling, rounding, saturation, result register
	qso_back #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.speed_scale    (speed_scale_q),
		.distance_scale (dist_scale_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.position_count (pos),
		.delta_count    (dlt),
		.speed_kmh_milli(kmh),
		.speed_mph_milli(mph),
		.distance_mm    (mm),
		.stopped        (stp)
	);

	assign m_axis_tdata = {7'b0, stp, mm, mph, kmh, dlt, pos};

endmodule
`default_nettype wire
